### sv/arps_pkg.sv
// shared types and constants for the affine rotated palette scanout
// no dependencies; imported by every module of the block
package arps_pkg;

	localparam int IMAGE_DEPTH = 65536;

	typedef enum logic [1:0] {
		ACT_PIXEL      = 2'd0,
		ACT_IMAGE_WR   = 2'd1,
		ACT_BANNER_WR  = 2'd2,
		ACT_PALETTE_WR = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		REG_START_X  = 3'd0,
		REG_START_Y  = 3'd1,
		REG_ACROSS_X = 3'd2,
		REG_ACROSS_Y = 3'd3,
		REG_DOWN_X   = 3'd4,
		REG_DOWN_Y   = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic [15:0] start_x;
		logic [15:0] start_y;
		logic [15:0] across_x;
		logic [15:0] across_y;
		logic [15:0] down_x;
		logic [15:0] down_y;
	} arps_cfg_t;

	// fields that travel on to the palette stage
	typedef struct packed {
		logic        pixel;
		logic        banner;
		logic        pal_we;
		logic [7:0]  pal_index;
		logic [15:0] pal_color;
		logic [7:0]  column;
		logic [7:0]  line;
		logic        frame_end;
	} arps_meta_t;

	// request leaving the scan stage
	typedef struct packed {
		arps_meta_t  meta;
		logic        image_we;
		logic        banner_we;
		logic [15:0] addr;
		logic [7:0]  data;
	} arps_req_t;

endpackage

### sv/affine_rotated_palette_scanout_core.sv
// top level of the affine rotated palette scanout: configuration registers,
// pipeline advance control; depends on arps_pkg, arps_scan and arps_lookup
module affine_rotated_palette_scanout_core #(
	parameter int TOP_LINES   = 8,
	parameter int MAIN_LINES  = 216,
	parameter int LINE_PIXELS = 240
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	// request channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  action,
	input  logic [15:0] store_address,
	input  logic [7:0]  store_byte,
	input  logic [7:0]  palette_index,
	input  logic [7:0]  red,
	input  logic [7:0]  green,
	input  logic [7:0]  blue,
	// pixel channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] color,
	output logic [7:0]  column,
	output logic [7:0]  line,
	output logic        frame_end
);
	// usage
	// requests arrive on the in_valid / in_stall channel: a pixel tick, an image
	// byte write, a banner byte write or a palette write (8-bit r,g,b packed to
	// rgb565). only pixel ticks produce a pixel on the out_valid / out_stall
	// channel; writes produce nothing but take effect in request order.
	// throughput is one request per clock while the receiver does not stall, set by a
	// three-register pipeline: request register (counters and coordinate step),
	// image/banner store read, palette read into the result register. a pixel
	// passes through these registers in order after its request is taken.
	// when the receiver stalls with a pixel waiting, the whole pipeline holds
	// and in_stall is raised in the same cycle; bubbles travel as empty stages.
	// reset clears the pipeline, the scan position and coordinates, and loads
	// the default step vectors (unit across x, unit down y). the stores are not
	// cleared, so image, banner and palette must be written before display.
	// configuration writes are taken at once on cfg_we and should be made
	// only while the pipeline is empty.
	import arps_pkg::*;

	arps_cfg_t  cfg_q;
	logic       adv;
	logic       valid_s1;
	arps_req_t  req_s1;

	// pipeline moves unless a finished pixel is held by the receiver
	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_x  <= 16'd0;
			cfg_q.start_y  <= 16'd0;
			cfg_q.across_x <= 16'd256;
			cfg_q.across_y <= 16'd0;
			cfg_q.down_x   <= 16'd0;
			cfg_q.down_y   <= 16'd256;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_START_X:  cfg_q.start_x  <= cfg_data;
				REG_START_Y:  cfg_q.start_y  <= cfg_data;
				REG_ACROSS_X: cfg_q.across_x <= cfg_data;
				REG_ACROSS_Y: cfg_q.across_y <= cfg_data;
				REG_DOWN_X:   cfg_q.down_x   <= cfg_data;
				REG_DOWN_Y:   cfg_q.down_y   <= cfg_data;
				default: ;  // unused indexes are ignored
			endcase
		end
	end

	arps_scan #(
		.TOP_LINES   (TOP_LINES),
		.MAIN_LINES  (MAIN_LINES),
		.LINE_PIXELS (LINE_PIXELS)
	) u_scan (
		.clk           (clk),
		.arst_n        (arst_n),
		.adv           (adv),
		.in_valid      (in_valid),
		.action        (action),
		.store_address (store_address),
		.store_byte    (store_byte),
		.palette_index (palette_index),
		.red           (red),
		.green         (green),
		.blue          (blue),
		.cfg           (cfg_q),
		.valid_s1      (valid_s1),
		.req_s1        (req_s1)
	);

	arps_lookup #(
		.TOP_LINES (TOP_LINES)
	) u_lookup (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv),
		.valid_s1    (valid_s1),
		.req_s1      (req_s1),
		.out_valid_q (out_valid),
		.color_q     (color),
		.column_q    (column),
		.line_q      (line),
		.frame_end_q (frame_end)
	);

endmodule

### sv/arps_scan.sv
// scan stage: pixel and line counters, 8.8 coordinate stepping, request register
// depends on arps_pkg
module arps_scan #(
	parameter int TOP_LINES   = 8,
	parameter int MAIN_LINES  = 216,
	parameter int LINE_PIXELS = 240
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  logic                in_valid,
	input  logic [1:0]          action,
	input  logic [15:0]         store_address,
	input  logic [7:0]          store_byte,
	input  logic [7:0]          palette_index,
	input  logic [7:0]          red,
	input  logic [7:0]          green,
	input  logic [7:0]          blue,
	input  arps_pkg::arps_cfg_t cfg,
	output logic                valid_s1,
	output arps_pkg::arps_req_t req_s1
);
	import arps_pkg::*;

	localparam int TOTAL_LINES  = TOP_LINES + MAIN_LINES;
	localparam int LW           = (TOTAL_LINES > 1) ? $clog2(TOTAL_LINES) : 1;
	localparam int BANNER_WORDS = 256 * TOP_LINES;
	localparam logic [LW-1:0] LINE_LAST       = LW'(TOTAL_LINES - 1);
	localparam logic [LW-1:0] LINE_FIRST_MAIN = LW'(TOP_LINES);
	localparam logic [7:0]    COL_LAST        = 8'(LINE_PIXELS - 1);

	logic [7:0]    col_q;
	logic [LW-1:0] line_q;
	logic [15:0]   cur_x_q, cur_y_q, row_x_q, row_y_q;

	logic          accept, pixel, banner, col_zero, first_main;
	logic [8:0]    line_ext;
	logic [15:0]   row_x_nxt, row_y_nxt, px, py;
	arps_req_t     req_d;

	always_comb begin
		accept     = in_valid & adv;
		pixel      = (action == ACT_PIXEL);
		banner     = (line_q < LINE_FIRST_MAIN);
		col_zero   = (col_q == '0);
		first_main = (line_q == LINE_FIRST_MAIN);
		line_ext   = 9'(line_q);

		// row start: load start on the first main line, else step down
		row_x_nxt = first_main ? cfg.start_x : row_x_q + cfg.down_x;
		row_y_nxt = first_main ? cfg.start_y : row_y_q + cfg.down_y;
		px        = col_zero ? row_x_nxt : cur_x_q;
		py        = col_zero ? row_y_nxt : cur_y_q;

		req_d.meta.pixel     = pixel;
		req_d.meta.banner    = banner;
		req_d.meta.pal_we    = (action == ACT_PALETTE_WR);
		req_d.meta.pal_index = palette_index;
		req_d.meta.pal_color = {red[7:3], green[7:2], blue[7:3]};
		req_d.meta.column    = col_q;
		req_d.meta.line      = line_ext[7:0];
		req_d.meta.frame_end = (line_q == LINE_LAST) && (col_q == COL_LAST);
		req_d.image_we       = (action == ACT_IMAGE_WR);
		req_d.banner_we      = (action == ACT_BANNER_WR) &&
			(store_address < 16'(BANNER_WORDS));
		req_d.data           = store_byte;
		if (!pixel) begin
			req_d.addr = store_address;
		end else if (banner) begin
			req_d.addr = {line_ext[7:0], col_q};
		end else begin
			req_d.addr = {py[15:8], px[15:8]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			col_q    <= '0;
			line_q   <= '0;
			cur_x_q  <= '0;
			cur_y_q  <= '0;
			row_x_q  <= '0;
			row_y_q  <= '0;
		end else begin
			if (adv) begin
				valid_s1 <= in_valid;
			end
			if (accept && pixel) begin
				if (col_q == COL_LAST) begin
					col_q  <= '0;
					line_q <= (line_q == LINE_LAST) ? '0 : LW'(line_q + 1'b1);
				end else begin
					col_q <= col_q + 8'd1;
				end
				if (!banner) begin
					cur_x_q <= px + cfg.across_x;
					cur_y_q <= py + cfg.across_y;
					if (col_zero) begin
						row_x_q <= row_x_nxt;
						row_y_q <= row_y_nxt;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			req_s1 <= req_d;
		end
	end

endmodule

### sv/arps_lookup.sv
// lookup stages: image and banner stores, palette store, result register
// depends on arps_pkg
module arps_lookup #(
	parameter int TOP_LINES = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  logic                valid_s1,
	input  arps_pkg::arps_req_t req_s1,
	output logic                out_valid_q,
	output logic [15:0]         color_q,
	output logic [7:0]          column_q,
	output logic [7:0]          line_q,
	output logic                frame_end_q
);
	import arps_pkg::*;

	localparam int BANNER_DEPTH = (TOP_LINES > 0) ? 256 * TOP_LINES : 1;
	localparam int BAW          = (BANNER_DEPTH > 1) ? $clog2(BANNER_DEPTH) : 1;

	logic [7:0]  image_mem  [IMAGE_DEPTH];
	logic [7:0]  banner_mem [BANNER_DEPTH];
	logic [15:0] pal_mem    [256];

	logic [BAW-1:0] ban_idx;
	logic [7:0]     img_rd_s2, ban_rd_s2, pal_idx;
	logic           valid_s2;
	arps_meta_t     meta_s2;

	assign ban_idx = req_s1.addr[BAW-1:0];
	assign pal_idx = meta_s2.banner ? ban_rd_s2 : img_rd_s2;

	// image and banner: write and read from the same stage keeps request order
	always_ff @(posedge clk) begin
		if (adv) begin
			if (valid_s1 && req_s1.image_we) begin
				image_mem[req_s1.addr] <= req_s1.data;
			end
			img_rd_s2 <= image_mem[req_s1.addr];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (valid_s1 && req_s1.banner_we) begin
				banner_mem[ban_idx] <= req_s1.data;
			end
			ban_rd_s2 <= banner_mem[ban_idx];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			meta_s2 <= req_s1.meta;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (valid_s2 && meta_s2.pal_we) begin
				pal_mem[meta_s2.pal_index] <= meta_s2.pal_color;
			end
			color_q     <= pal_mem[pal_idx];
			column_q    <= meta_s2.column;
			line_q      <= meta_s2.line;
			frame_end_q <= meta_s2.frame_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s2    <= valid_s1;
			out_valid_q <= valid_s2 & meta_s2.pixel;
		end
	end

endmodule

### test/arps_scan_checker.sv
`timescale 1ns / 100ps
// pixel checker for the affine rotated palette scanout: tracks register writes,
// keeps its own copy of the stores and the scan position, and compares every pixel
// depends on arps_pkg for the action, register and configuration types
module arps_scan_checker #(
	parameter int TOP_LINES   = 8,
	parameter int MAIN_LINES  = 216,
	parameter int LINE_PIXELS = 240
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [1:0]  action,
	input  logic [15:0] store_address,
	input  logic [7:0]  store_byte,
	input  logic [7:0]  palette_index,
	input  logic [7:0]  red,
	input  logic [7:0]  green,
	input  logic [7:0]  blue,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [15:0] color,
	input  logic [7:0]  column,
	input  logic [7:0]  line,
	input  logic        frame_end,
	output int          fail_count,
	output int          expected_left
);
	import arps_pkg::*;

	localparam int FRAME_LINES  = TOP_LINES + MAIN_LINES;
	localparam int BANNER_BYTES = TOP_LINES * 256;

	typedef struct packed {
		logic [15:0] color;
		logic [7:0]  column;
		logic [7:0]  line;
		logic        frame_end;
	} pixel_t;

	arps_cfg_t   geometry;
	logic [7:0]  image_copy [IMAGE_DEPTH];
	logic [7:0]  banner_copy [32 * 256];
	logic [15:0] palette_copy [256];
	logic [15:0] walk_x, walk_y, row_x, row_y;
	int          col_cnt, line_cnt;
	pixel_t      pixels_due [$];

	// one accepted request: a store update, or the next pixel of the scan
	task automatic scan_request();
		pixel_t      due;
		logic [15:0] px, py;
		case (action_t'(action))
		ACT_IMAGE_WR: image_copy[store_address] = store_byte;
		ACT_BANNER_WR: if (int'(store_address) < BANNER_BYTES)
			banner_copy[store_address] = store_byte;
		ACT_PALETTE_WR: palette_copy[palette_index] = {red[7:3], green[7:2], blue[7:3]};
		default: begin
			if (line_cnt < TOP_LINES) begin
				due.color = palette_copy[banner_copy[line_cnt * 256 + col_cnt]];
			end else begin
				// column 0 reloads the row start, later columns continue along the line
				if (col_cnt == 0) begin
					if (line_cnt == TOP_LINES) begin
						row_x = geometry.start_x;
						row_y = geometry.start_y;
					end else begin
						row_x = row_x + geometry.down_x;
						row_y = row_y + geometry.down_y;
					end
					px = row_x;
					py = row_y;
				end else begin
					px = walk_x;
					py = walk_y;
				end
				due.color = palette_copy[image_copy[{py[15:8], px[15:8]}]];
				walk_x = px + geometry.across_x;
				walk_y = py + geometry.across_y;
			end
			due.column    = 8'(col_cnt);
			due.line      = 8'(line_cnt);
			due.frame_end = (line_cnt == FRAME_LINES - 1) && (col_cnt == LINE_PIXELS - 1);
			pixels_due.push_back(due);
			col_cnt++;
			if (col_cnt == LINE_PIXELS) begin
				col_cnt  = 0;
				line_cnt = (line_cnt + 1 == FRAME_LINES) ? 0 : line_cnt + 1;
			end
		end
		endcase
	endtask

	task automatic check_pixel();
		pixel_t due;
		if (pixels_due.size() == 0) begin
			$error("pixel at line %0d column %0d with no request waiting", line, column);
			fail_count++;
		end else begin
			due = pixels_due.pop_front();
			if (color !== due.color) begin
				$error("color: expected %h, got %h", due.color, color);
				fail_count++;
			end
			if (column !== due.column) begin
				$error("column: expected %0d, got %0d", due.column, column);
				fail_count++;
			end
			if (line !== due.line) begin
				$error("line: expected %0d, got %0d", due.line, line);
				fail_count++;
			end
			if (frame_end !== due.frame_end) begin
				$error("frame_end: expected %b, got %b", due.frame_end, frame_end);
				fail_count++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			geometry   = {16'h0000, 16'h0000, 16'h0100, 16'h0000, 16'h0000, 16'h0100};
			walk_x     = '0;
			walk_y     = '0;
			row_x      = '0;
			row_y      = '0;
			col_cnt    = 0;
			line_cnt   = 0;
			fail_count = 0;
			pixels_due.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
				REG_START_X:  geometry.start_x  = cfg_data;
				REG_START_Y:  geometry.start_y  = cfg_data;
				REG_ACROSS_X: geometry.across_x = cfg_data;
				REG_ACROSS_Y: geometry.across_y = cfg_data;
				REG_DOWN_X:   geometry.down_x   = cfg_data;
				REG_DOWN_Y:   geometry.down_y   = cfg_data;
				default: ;
				endcase
			end
			if (in_valid && !in_stall)
				scan_request();
			if (out_valid && !out_stall)
				check_pixel();
		end
		expected_left <= pixels_due.size();
	end

endmodule

### test/tb_affine_rotated_palette_scanout_core.sv
`timescale 1ns / 100ps
// testbench top for affine_rotated_palette_scanout_core: drives requests,
// register writes and output back-pressure; arps_scan_checker does the checking
// depends on arps_pkg, the block and test/arps_scan_checker.sv
module tb_affine_rotated_palette_scanout_core;
	import arps_pkg::*;

	localparam int TOP_LINES     = 8;
	localparam int MAIN_LINES    = 216;
	localparam int LINE_PIXELS   = 240;
	localparam int FRAME_LINES   = TOP_LINES + MAIN_LINES;
	localparam int BANNER_BYTES  = TOP_LINES * 256;
	localparam int PHASES        = 8;
	// quiet cycles after the last pixel before registers change or the verdict
	localparam int SETTLE_CYCLES = 16;
	// roughly 1200 requests in the slowest legal run, plus the drains, with a wide
	// margin on top
	localparam int CYCLE_LIMIT   = 200_000;

	// register indexes beyond the six that exist, which the block must ignore
	localparam logic [2:0] CFG_BEYOND_LO = 3'd6;
	localparam logic [2:0] CFG_BEYOND_HI = 3'd7;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        cfg_we        = 1'b0;
	logic [2:0]  cfg_index     = '0;
	logic [15:0] cfg_data      = '0;
	logic        in_valid      = 1'b0;
	logic        in_stall;
	action_t     action        = ACT_PIXEL;
	logic [15:0] store_address = '0;
	logic [7:0]  store_byte    = '0;
	logic [7:0]  palette_index = '0;
	logic [7:0]  red           = '0;
	logic [7:0]  green         = '0;
	logic [7:0]  blue          = '0;
	logic        out_valid;
	logic        out_stall     = 1'b0;
	logic [15:0] color;
	logic [7:0]  column;
	logic [7:0]  line;
	logic        frame_end;

	int failures;
	int pixels_waiting;
	int cycle_count = 0;

	// idle pattern state, one pair per side
	int in_mode  = 0;
	int in_left  = 0;
	int out_mode = 0;
	int out_left = 0;

	// scan position as seen from the request side, and which banner bytes hold data
	int pixels_sent = 0;
	bit banner_written [BANNER_BYTES];

	always #1 clk = ~clk;

	affine_rotated_palette_scanout_core #(
		.TOP_LINES  (TOP_LINES),
		.MAIN_LINES (MAIN_LINES),
		.LINE_PIXELS(LINE_PIXELS)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.action       (action),
		.store_address(store_address),
		.store_byte   (store_byte),
		.palette_index(palette_index),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.color        (color),
		.column       (column),
		.line         (line),
		.frame_end    (frame_end)
	);

	arps_scan_checker #(
		.TOP_LINES  (TOP_LINES),
		.MAIN_LINES (MAIN_LINES),
		.LINE_PIXELS(LINE_PIXELS)
	) pixel_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.action       (action),
		.store_address(store_address),
		.store_byte   (store_byte),
		.palette_index(palette_index),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.color        (color),
		.column       (column),
		.line         (line),
		.frame_end    (frame_end),
		.fail_count   (failures),
		.expected_left(pixels_waiting)
	);

	// idle cycles before the next request or acceptance; the pattern changes every
	// 32 draws between no idling at all, a flat 0..9 and rare bursts
	function automatic int draw_gap(inout int mode, inout int left);
		if (left == 0) begin
			mode = $urandom_range(0, 3);
			left = 32;
		end
		left--;
		case (mode)
		2: return $urandom_range(0, 9);
		3: return ($urandom_range(0, 7) == 0) ? $urandom_range(0, 9) : 0;
		default: return 0;
		endcase
	endfunction

	// present one request and hold it until the block takes it; valid stays high
	// afterwards so that back-to-back requests never drop it within a step
	task automatic send_request(input action_t act, input logic [15:0] addr,
			input logic [7:0] data, input logic [7:0] entry,
			input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
		int gap;
		gap = draw_gap(in_mode, in_left);
		if (act == ACT_PIXEL)
			pixels_sent++;
		else if (act == ACT_BANNER_WR && int'(addr) < BANNER_BYTES)
			banner_written[addr] = 1'b1;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid      <= 1'b1;
		action        <= act;
		store_address <= addr;
		store_byte    <= data;
		palette_index <= entry;
		red           <= r;
		green         <= g;
		blue          <= b;
		do @(posedge clk); while (in_stall);
	endtask

	// a banner pixel's byte gets a value before the pixel tick if it has none yet
	task automatic send_pixel();
		int pos;
		int addr;
		pos  = pixels_sent % (FRAME_LINES * LINE_PIXELS);
		addr = (pos / LINE_PIXELS) * 256 + pos % LINE_PIXELS;
		if (addr < BANNER_BYTES && !banner_written[addr])
			send_request(ACT_BANNER_WR, 16'(addr), 8'($urandom), 8'($urandom),
				8'($urandom), 8'($urandom), 8'($urandom));
		send_request(ACT_PIXEL, 16'($urandom), 8'($urandom), 8'($urandom),
			8'($urandom), 8'($urandom), 8'($urandom));
	endtask

	// mostly pixel ticks, the rest store writes; don't-care fields stay random too
	task automatic send_random();
		action_t     act;
		logic [15:0] addr;
		int          pick;
		pick = $urandom_range(0, 99);
		if (pick < 60)
			act = ACT_PIXEL;
		else if (pick < 72)
			act = ACT_IMAGE_WR;
		else if (pick < 88)
			act = ACT_BANNER_WR;
		else
			act = ACT_PALETTE_WR;
		// main lines read image bytes that are mostly never written, so pixel
		// ticks stop at the end of the banner
		if (act == ACT_PIXEL && pixels_sent >= TOP_LINES * LINE_PIXELS)
			act = ACT_IMAGE_WR;
		if (act == ACT_PIXEL) begin
			send_pixel();
		end else begin
			addr = 16'($urandom);
			// banner writes mostly land inside the banner, some fall beyond it
			if (act == ACT_BANNER_WR && $urandom_range(0, 3) != 0)
				addr = 16'($urandom_range(0, BANNER_BYTES - 1));
			send_request(act, addr, 8'($urandom), 8'($urandom), 8'($urandom),
				8'($urandom), 8'($urandom));
		end
	endtask

	// enable is left high between writes and lowered by the caller
	task automatic write_reg(input logic [2:0] index, input logic [15:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= index;
		cfg_data  <= value;
		@(posedge clk);
	endtask

	task automatic program_regs(input arps_cfg_t geometry);
		write_reg(REG_START_X, geometry.start_x);
		write_reg(REG_START_Y, geometry.start_y);
		write_reg(REG_ACROSS_X, geometry.across_x);
		write_reg(REG_ACROSS_Y, geometry.across_y);
		write_reg(REG_DOWN_X, geometry.down_x);
		write_reg(REG_DOWN_Y, geometry.down_y);
		// a write to a missing register must leave the others alone
		write_reg($urandom_range(0, 1) ? CFG_BEYOND_LO : CFG_BEYOND_HI, 16'($urandom));
		cfg_we <= 1'b0;
	endtask

	// stop requesting, wait for every pixel owed, then let the pipeline go quiet
	task automatic drain_pixels();
		in_valid <= 1'b0;
		do @(posedge clk); while (pixels_waiting != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// output back-pressure: a drawn stall before each pixel is taken
	initial begin
		int hold;
		forever begin
			hold = draw_gap(out_mode, out_left);
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		arps_cfg_t geometry;
		int        run_len;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// every palette entry gets a value before any pixel can read it
		for (int entry = 0; entry < 256; entry++)
			send_request(ACT_PALETTE_WR, 16'($urandom), 8'($urandom), 8'(entry),
				8'($urandom), 8'($urandom), 8'($urandom));

		// colour packing: all ones, all zeros, only the dropped low bits, only the kept bits
		send_request(ACT_PALETTE_WR, 16'h0000, 8'h00, 8'h00, 8'hff, 8'hff, 8'hff);
		send_request(ACT_PALETTE_WR, 16'hffff, 8'hff, 8'hff, 8'h00, 8'h00, 8'h00);
		send_request(ACT_PALETTE_WR, 16'h0000, 8'h00, 8'h5a, 8'h07, 8'h03, 8'h07);
		send_request(ACT_PALETTE_WR, 16'h0000, 8'h00, 8'ha5, 8'hf8, 8'hfc, 8'hf8);
		// banner first and last entries, then writes just past the banner and at the
		// top of the address range, which must be dropped rather than wrap onto entry 0
		send_request(ACT_BANNER_WR, 16'h0000, 8'h5a, 8'h00, 8'h00, 8'h00, 8'h00);
		send_request(ACT_BANNER_WR, 16'(BANNER_BYTES - 1), 8'hff, 8'hff, 8'hff, 8'hff, 8'hff);
		send_request(ACT_BANNER_WR, 16'(BANNER_BYTES), 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
		send_request(ACT_BANNER_WR, 16'hffff, 8'ha5, 8'hff, 8'hff, 8'hff, 8'hff);
		// image corners and a middle entry
		send_request(ACT_IMAGE_WR, 16'h0000, 8'h00, 8'hff, 8'hff, 8'hff, 8'hff);
		send_request(ACT_IMAGE_WR, 16'hffff, 8'hff, 8'h00, 8'h00, 8'h00, 8'h00);
		send_request(ACT_IMAGE_WR, 16'h8080, 8'ha5, 8'h5a, 8'h5a, 8'h5a, 8'h5a);
		// first banner pixels of the frame under the reset register values
		repeat (8)
			send_pixel();

		// register settings change only once the block is quiet, which lands them
		// between arbitrary banner pixels; the banner output must not move with them
		for (int phase = 0; phase < PHASES; phase++) begin
			drain_pixels();
			// order: start_x, start_y, across_x, across_y, down_x, down_y
			case (phase)
			0: geometry = {16'h0000, 16'h0000, 16'h0100, 16'h0000, 16'h0000, 16'h0100};
			1: geometry = {16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'hffff, 16'h0000};
			2: geometry = {16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'h0000, 16'hffff};
			// roughly a 45 degree rotation
			3: geometry = {16'h0000, 16'h0000, 16'h00b5, 16'h00b5, 16'hff4b, 16'h00b5};
			// zero steps: the whole main area shows one image byte
			4: geometry = {16'hffff, 16'h0001, 16'h0000, 16'h0000, 16'h0000, 16'h0000};
			default: geometry = {$urandom, $urandom, $urandom};
			endcase
			program_regs(geometry);
			run_len = 60 + $urandom_range(0, 20);
			repeat (run_len) send_random();
		end

		drain_pixels();
		if (failures == 0 && pixels_waiting == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
